>>> design/hpn_pkg.sv
package hpn_pkg;

	localparam int NUM_BINS = 256;
	localparam int BIN_AW   = 8;
	localparam int CMD_W    = 2;
	localparam int FIELD_W  = 32;
	localparam int FRAC_W   = 17;
	localparam int STEP_W   = 5;

	localparam logic [CMD_W-1:0] OP_CLEAR = 2'd0;
	localparam logic [CMD_W-1:0] OP_ADD   = 2'd1;
	localparam logic [CMD_W-1:0] OP_READ  = 2'd2;

	localparam logic [FRAC_W-1:0] FRAC_ONE = 17'h10000;

	typedef struct packed {
		logic take;
		logic clear;
		logic bump;
		logic div_load;
		logic div_step;
		logic out_load;
	} hpn_ctl_t;

	typedef struct packed {
		logic peak_zero;
	} hpn_sts_t;

endpackage

>>> design/hpn_if.sv
interface hpn_req_if import hpn_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [CMD_W-1:0]    cmd;
	logic [BIN_AW-1:0]   sample_byte;
	logic [BIN_AW-1:0]   bin_index;

	modport source(output valid, cmd, sample_byte, bin_index, input ready);
	modport sink(input valid, cmd, sample_byte, bin_index, output ready);
endinterface

interface hpn_rsp_if import hpn_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [FIELD_W-1:0]  bin_count;
	logic [FRAC_W-1:0]   fraction;
	logic [FIELD_W-1:0]  peak_count;

	modport source(output valid, bin_count, fraction, peak_count, input ready);
	modport sink(input valid, bin_count, fraction, peak_count, output ready);
endinterface

>>> design/byte_histogram_peak_normalized_core.sv
// channel  dir  beat content                          handshake
// req      in   cmd, sample_byte, bin_index           valid/ready
// rsp      out  bin_count, fraction, peak_count       valid/ready
//
// clear completes on acceptance; add reads the bin memory, then writes it back
// read: memory read, 17 restoring divider steps, result load;
// the divider steps are skipped when the peak is zero
// reset clears the bin valid bits and the peak at once, no sweep of the memory
// one item at a time; a read stalls at its result load while the previous result is still unread
module byte_histogram_peak_normalized_core import hpn_pkg::*; #(
	parameter int COUNT_WIDTH = 32
) (
	input  logic       clk,
	input  logic       arst_n,
	hpn_req_if.sink    req,
	hpn_rsp_if.source  rsp
);

	hpn_ctl_t ctl;
	hpn_sts_t sts;

	hpn_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req.valid),
		.req_cmd  (req.cmd),
		.req_ready(req.ready),
		.rsp_valid(rsp.valid),
		.rsp_ready(rsp.ready),
		.sts      (sts),
		.ctl      (ctl)
	);

	hpn_dp #(
		.COUNT_WIDTH(COUNT_WIDTH)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.ctl            (ctl),
		.sts            (sts),
		.req_cmd        (req.cmd),
		.req_sample_byte(req.sample_byte),
		.req_bin_index  (req.bin_index),
		.bin_count      (rsp.bin_count),
		.fraction       (rsp.fraction),
		.peak_count     (rsp.peak_count)
	);

endmodule

>>> design/hpn_ram.sv
module hpn_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

>>> design/hpn_ctrl.sv
module hpn_ctrl import hpn_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	input  logic [CMD_W-1:0] req_cmd,
	output logic             req_ready,
	output logic             rsp_valid,
	input  logic             rsp_ready,
	input  hpn_sts_t         sts,
	output hpn_ctl_t         ctl
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_ADD,
		S_RDD,
		S_DIV,
		S_OUT
	} state_t;

	state_t              state_q;
	logic [STEP_W-1:0]   step_q;
	logic                rsp_valid_q;
	logic                accept;

	assign req_ready = (state_q == S_IDLE);
	assign accept    = req_valid && req_ready;
	assign rsp_valid = rsp_valid_q;

	always_comb begin
		ctl          = '0;
		ctl.take     = accept;
		ctl.clear    = accept && (req_cmd == OP_CLEAR);
		ctl.bump     = (state_q == S_ADD);
		ctl.div_load = (state_q == S_RDD);
		ctl.div_step = (state_q == S_DIV);
		ctl.out_load = (state_q == S_OUT) && (!rsp_valid_q || rsp_ready);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			step_q      <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (ctl.out_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						unique case (req_cmd)
							OP_ADD:  state_q <= S_ADD;
							OP_READ: state_q <= S_RDD;
							default: state_q <= S_IDLE;
						endcase
					end
				end
				S_ADD: begin
					state_q <= S_IDLE;
				end
				S_RDD: begin
					step_q  <= STEP_W'(FRAC_W - 1);
					state_q <= sts.peak_zero ? S_OUT : S_DIV;
				end
				S_DIV: begin
					step_q <= step_q - 1'b1;
					if (step_q == '0) begin
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (ctl.out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// a full result register is never overwritten before its beat goes out
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.out_load |-> (!rsp_valid_q || rsp_ready))
		else $error("result overwritten");

	// the divider goes on to the result load after its last step
	a_div_len: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV && step_q == '0) |=> (state_q == S_OUT))
		else $error("divider step count");

endmodule

>>> design/hpn_dp.sv
module hpn_dp import hpn_pkg::*; #(
	parameter int COUNT_WIDTH = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  hpn_ctl_t           ctl,
	output hpn_sts_t           sts,
	input  logic [CMD_W-1:0]   req_cmd,
	input  logic [BIN_AW-1:0]  req_sample_byte,
	input  logic [BIN_AW-1:0]  req_bin_index,
	output logic [FIELD_W-1:0] bin_count,
	output logic [FRAC_W-1:0]  fraction,
	output logic [FIELD_W-1:0] peak_count
);

	localparam int CW   = COUNT_WIDTH;
	localparam int EXTW = (CW > FIELD_W) ? CW : FIELD_W;

	logic [NUM_BINS-1:0] valid_q;
	logic [CW-1:0]       peak_q;
	logic [BIN_AW-1:0]   idx_q;
	logic [BIN_AW-1:0]   rd_addr;
	logic [CW-1:0]       rd_data;
	logic [CW-1:0]       cur;
	logic [CW-1:0]       inc;
	logic [CW-1:0]       cnt_q;
	logic [CW:0]         rem_q;
	logic [CW:0]         rem;
	logic                ge;
	logic [FRAC_W-1:0]   quo_q;
	logic [CW-1:0]       out_cnt_q;
	logic [CW-1:0]       out_peak_q;
	logic [FRAC_W-1:0]   out_frac_q;
	logic [EXTW-1:0]     cnt_ext;
	logic [EXTW-1:0]     peak_ext;

	assign rd_addr = (req_cmd == OP_ADD) ? req_sample_byte : req_bin_index;

	hpn_ram #(
		.WIDTH(CW),
		.DEPTH(NUM_BINS)
	) u_bins (
		.clk    (clk),
		.wr_en  (ctl.bump),
		.wr_addr(idx_q),
		.wr_data(inc),
		.rd_en  (ctl.take),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	// a bin not written since the last clear reads as empty
	assign cur = valid_q[idx_q] ? rd_data : '0;
	assign inc = (&cur) ? cur : cur + CW'(1);

	// restoring division, one quotient bit per step
	assign ge  = (rem_q >= {1'b0, peak_q});
	assign rem = ge ? (rem_q - {1'b0, peak_q}) : rem_q;

	assign sts.peak_zero = (peak_q == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			peak_q  <= '0;
		end else if (ctl.clear) begin
			valid_q <= '0;
			peak_q  <= '0;
		end else if (ctl.bump) begin
			valid_q[idx_q] <= 1'b1;
			if (inc > peak_q) begin
				peak_q <= inc;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.take) begin
			idx_q <= rd_addr;
		end
		if (ctl.div_load) begin
			cnt_q <= cur;
			rem_q <= {1'b0, cur};
			quo_q <= '0;
		end else if (ctl.div_step) begin
			rem_q <= {rem[CW-1:0], 1'b0};
			quo_q <= {quo_q[FRAC_W-2:0], ge};
		end
		if (ctl.out_load) begin
			out_cnt_q  <= cnt_q;
			out_peak_q <= peak_q;
			out_frac_q <= quo_q;
		end
	end

	assign cnt_ext    = EXTW'(out_cnt_q);
	assign peak_ext   = EXTW'(out_peak_q);
	assign bin_count  = cnt_ext[FIELD_W-1:0];
	assign peak_count = peak_ext[FIELD_W-1:0];
	assign fraction   = out_frac_q;

	a_clear_peak: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.clear |=> sts.peak_zero)
		else $error("peak not zero after clear");

	a_peak_rises: assert property (@(posedge clk) disable iff (!arst_n)
		!ctl.clear |=> (peak_q >= $past(peak_q)))
		else $error("peak fell without clear");

	// the peak bounds every bin, so the ratio never exceeds one
	a_frac_range: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.out_load |=> (out_frac_q <= FRAC_ONE))
		else $error("fraction above one");

endmodule

>>> tb/byte_histogram_peak_normalized_core_tb.sv
module byte_histogram_peak_normalized_core_tb;
	import hpn_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	// narrow counts so that a bin can be driven into saturation
	localparam int COUNT_W = 8;
	localparam int ITEM_TARGET = 800;
	localparam int CYCLE_LIMIT = 300000;
	localparam int DRAIN_CYCLES = 40;
	localparam logic [CMD_W-1:0] OP_NONE = 2'd3;

	typedef struct packed {
		logic [CMD_W-1:0]  cmd;
		logic [BIN_AW-1:0] sample_byte;
		logic [BIN_AW-1:0] bin_index;
	} hist_beat_t;

	typedef struct packed {
		logic [FIELD_W-1:0] bin_count;
		logic [FRAC_W-1:0]  fraction;
		logic [FIELD_W-1:0] peak_count;
	} bin_report_t;

	logic clk = 1'b0;
	logic arst_n;

	always #6 clk = ~clk;

	hpn_req_if req_ch();
	hpn_rsp_if rsp_ch();

	byte_histogram_peak_normalized_core #(
		.COUNT_WIDTH(COUNT_W)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.rsp(rsp_ch)
	);

	hist_beat_t  beats_to_send[$];
	bin_report_t reads_due[$];

	logic [COUNT_W-1:0] bin_tally[NUM_BINS];
	logic               bin_seen[NUM_BINS];
	logic [COUNT_W-1:0] peak_level;

	int errors = 0;
	int counted = 0;
	int cycle_count = 0;
	int gap_left = 0;
	int burst_left = 1;
	logic [8:0] rx_phase;

	task automatic histogram_apply(input hist_beat_t b);
		logic [COUNT_W-1:0] c;
		logic [63:0] c64;
		logic [63:0] q;
		bin_report_t r;
		int i;
		case (b.cmd)
			OP_CLEAR: begin
				for (i = 0; i < NUM_BINS; i++)
					bin_seen[i] = 1'b0;
				peak_level = '0;
			end
			OP_ADD: begin
				c = bin_seen[b.sample_byte] ? bin_tally[b.sample_byte] : '0;
				if (c != {COUNT_W{1'b1}})
					c = c + 1'b1;
				bin_tally[b.sample_byte] = c;
				bin_seen[b.sample_byte] = 1'b1;
				if (c > peak_level)
					peak_level = c;
			end
			OP_READ: begin
				c = bin_seen[b.bin_index] ? bin_tally[b.bin_index] : '0;
				c64 = 64'(c);
				q = '0;
				if (peak_level != '0)
					q = (c64 << 16) / 64'(peak_level);
				r.bin_count = c64[FIELD_W-1:0];
				r.fraction = q[FRAC_W-1:0];
				r.peak_count = FIELD_W'(peak_level);
				reads_due = {reads_due, r};
			end
			default: begin
			end
		endcase
	endtask

	task automatic queue_beat(input logic [CMD_W-1:0] c, input int s, input int b);
		hist_beat_t x;
		x.cmd = c;
		x.sample_byte = s[BIN_AW-1:0];
		x.bin_index = b[BIN_AW-1:0];
		beats_to_send = {beats_to_send, x};
		if (c != OP_NONE)
			counted++;
	endtask

	function automatic int any_byte();
		return $urandom_range(0, 255);
	endfunction

	// request driver
	always @(posedge clk or negedge arst_n) begin
		hist_beat_t nxt;
		if (!arst_n) begin
			req_ch.valid <= 1'b0;
			req_ch.cmd <= OP_CLEAR;
			req_ch.sample_byte <= '0;
			req_ch.bin_index <= '0;
		end else begin
			if (req_ch.valid && req_ch.ready)
				histogram_apply({req_ch.cmd, req_ch.sample_byte, req_ch.bin_index});
			if (!req_ch.valid || req_ch.ready) begin
				if (gap_left > 0 || beats_to_send.size() == 0) begin
					if (gap_left > 0)
						gap_left--;
					req_ch.valid <= 1'b0;
				end else begin
					nxt = beats_to_send.pop_front();
					req_ch.valid <= 1'b1;
					req_ch.cmd <= nxt.cmd;
					req_ch.sample_byte <= nxt.sample_byte;
					req_ch.bin_index <= nxt.bin_index;
					burst_left--;
					if (burst_left == 0) begin
						burst_left = $urandom_range(1, 24);
						gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
					end
				end
			end
		end
	end

	// response monitor with its own stall pattern
	always @(posedge clk or negedge arst_n) begin
		bin_report_t want;
		logic rdy;
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
			rx_phase <= '0;
		end else begin
			rx_phase <= rx_phase + 1'b1;
			case (rx_phase[8:7])
				2'd0: rdy = 1'b1;
				2'd1: rdy = 1'($urandom_range(0, 1));
				2'd2: rdy = (rx_phase[3:0] < 4'd3);
				default: rdy = ($urandom_range(0, 3) != 0);
			endcase
			rsp_ch.ready <= rdy;
			if (rsp_ch.valid && rsp_ch.ready) begin
				if (reads_due.size() == 0) begin
					$display("%0t unexpected beat: bin_count %0d fraction %0d peak_count %0d",
						$time, rsp_ch.bin_count, rsp_ch.fraction, rsp_ch.peak_count);
					errors++;
				end else begin
					want = reads_due.pop_front();
					if (rsp_ch.bin_count !== want.bin_count) begin
						$display("%0t bin_count exp %0d act %0d",
							$time, want.bin_count, rsp_ch.bin_count);
						errors++;
					end
					if (rsp_ch.fraction !== want.fraction) begin
						$display("%0t fraction exp %0d act %0d",
							$time, want.fraction, rsp_ch.fraction);
						errors++;
					end
					if (rsp_ch.peak_count !== want.peak_count) begin
						$display("%0t peak_count exp %0d act %0d",
							$time, want.peak_count, rsp_ch.peak_count);
						errors++;
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	initial begin
		int i;
		int n;
		int span;
		int base;
		int r;
		int add_pct;
		logic flood;

		arst_n = 1'b0;
		for (i = 0; i < NUM_BINS; i++) begin
			bin_tally[i] = '0;
			bin_seen[i] = 1'b0;
		end
		peak_level = '0;

		// reads with an empty histogram and a zero peak, then reads after adds to bins 0 and 255
		queue_beat(OP_READ, any_byte(), 0);
		queue_beat(OP_READ, any_byte(), 255);
		queue_beat(OP_ADD, 0, any_byte());
		queue_beat(OP_ADD, 255, any_byte());
		queue_beat(OP_ADD, 255, any_byte());
		queue_beat(OP_READ, any_byte(), 0);
		queue_beat(OP_READ, any_byte(), 255);
		queue_beat(OP_READ, any_byte(), 128);
		// unused command leaves everything alone
		queue_beat(OP_NONE, 255, 255);
		queue_beat(OP_READ, 0, 255);
		queue_beat(OP_CLEAR, 255, 255);
		queue_beat(OP_READ, any_byte(), 255);
		// bin comes back from zero after a clear, not from its old count
		queue_beat(OP_ADD, 255, 0);
		queue_beat(OP_READ, any_byte(), 255);
		queue_beat(OP_ADD, 'hAA, 'h55);
		queue_beat(OP_ADD, 'hAA, 'h55);
		queue_beat(OP_ADD, 'hAA, 'h55);
		queue_beat(OP_READ, 'h55, 'hAA);
		queue_beat(OP_READ, 'h00, 'hFF);
		queue_beat(OP_NONE, 0, 0);
		queue_beat(OP_CLEAR, 0, 0);
		queue_beat(OP_READ, 'h55, 'hAA);

		// data sets of random content; the first one floods a single bin
		flood = 1'b1;
		while (counted < ITEM_TARGET) begin
			span = flood ? 1 : (($urandom_range(0, 3) == 0) ? 256 : $urandom_range(1, 16));
			base = any_byte();
			n = flood ? $urandom_range(300, 320) : $urandom_range(5, 60);
			add_pct = flood ? 90 : 60;
			if (flood || $urandom_range(0, 4) != 0)
				queue_beat(OP_CLEAR, any_byte(), any_byte());
			for (i = 0; i < n; i++) begin
				r = $urandom_range(0, 99);
				if (r < add_pct)
					queue_beat(OP_ADD, base + $urandom_range(0, span - 1), any_byte());
				else if (r < 94)
					queue_beat(OP_READ, any_byte(), $urandom_range(0, 1) ?
						base + $urandom_range(0, span - 1) : any_byte());
				else if (r < 98)
					queue_beat(OP_NONE, any_byte(), any_byte());
				else
					queue_beat(OP_CLEAR, any_byte(), any_byte());
			end
			queue_beat(OP_READ, any_byte(), base);
			queue_beat(OP_READ, any_byte(), any_byte());
			flood = ($urandom_range(0, 9) == 0);
		end

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (beats_to_send.size() != 0 || req_ch.valid)
			@(posedge clk);
		while (reads_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
